// ===== hdl/rcc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcc_pkg: shared types and constants for the ring clearance check
// Queue entry layout, configuration bundle and verdict reason codes.
// ----------------------------------------------------------------------------
package rcc_pkg;

    localparam int QUEUE_DEPTH = 2;

    localparam logic [2:0] RC_SAFE     = 3'd0;
    localparam logic [2:0] RC_MISSING  = 3'd1;
    localparam logic [2:0] RC_DISABLED = 3'd2;
    localparam logic [2:0] RC_EMPTY    = 3'd3;
    localparam logic [2:0] RC_BOUNDS   = 3'd4;
    localparam logic [2:0] RC_LOW      = 3'd5;

    localparam logic [2:0] CFG_CENTER_X   = 3'd0;
    localparam logic [2:0] CFG_CENTER_Y   = 3'd1;
    localparam logic [2:0] CFG_PATH_H     = 3'd2;
    localparam logic [2:0] CFG_CIRCLE_R   = 3'd3;
    localparam logic [2:0] CFG_BODY_R     = 3'd4;
    localparam logic [2:0] CFG_HALF_H     = 3'd5;
    localparam logic [2:0] CFG_CLOUD_REQ  = 3'd6;
    localparam logic [2:0] CFG_CHECK_EN   = 3'd7;

    typedef struct packed {
        logic signed [31:0] cen_x;
        logic signed [31:0] cen_y;
        logic signed [31:0] path_height;
        logic [30:0]        circle_radius;
        logic [30:0]        body_radius;
        logic [30:0]        half_height;
        logic               cloud_required;
        logic               check_enable;
    } t_cfg;

    typedef struct packed {
        logic               is_empty;
        logic               finite;
        logic               in_slab;
        logic               last;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic [31:0]        ax;
        logic [31:0]        ay;
    } t_entry;

endpackage

// ===== hdl/ring_clearance_check.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ring_clearance_check: clearance verdict for a circular path in a cloud
// Front classifier, two-entry queue and an arithmetic back end.
// ----------------------------------------------------------------------------
// Points stream in one request at a time. A point outside the height slab (or
// not finite) is consumed in the back end's idle state; a slab point passes
// through the squares, their sum, the bit-serial square root (one result bit
// per cycle, the rate-setting loop), the gap update and the return to idle.
// The last item of a cloud, or a no_points item, then loads the verdict into
// the output register once the output is free. The front classifies in the
// accept cycle and the two-entry queue lets inputs land while the root runs.
// Config writes are always accepted; write only while idle.
// ----------------------------------------------------------------------------
module ring_clearance_check #(
    parameter int COUNT_BITS = 24
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // input stream
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    input  logic [95:0]  i_s_tdata,   // px[31:0], py[63:32], pz[95:64]
    input  logic [1:0]   i_s_tuser,   // finite[0], no_points[1]
    input  logic         i_s_tlast,   // last_point
    // verdict stream
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    output logic [63:0]  o_m_tdata,   // safe[0], reason_code[3:1],
                                      // slab_count[27:4], min_gap[59:28],
                                      // inside_bounds[60], zero[63:61]
    // configuration writes
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [2:0]   i_cfg_index,
    input  logic [31:0]  i_cfg_data
);
    rcc_pkg::t_cfg   r_cfg;
    rcc_pkg::t_entry front_entry, q_entry;
    logic            q_full, q_empty, q_pop, push;

    assign o_cfg_ready = 1'b1;
    assign o_s_tready  = !q_full;
    assign push        = i_s_tvalid && !q_full;

    // register file
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.cen_x          <= '0;
            r_cfg.cen_y          <= '0;
            r_cfg.path_height    <= '0;
            r_cfg.circle_radius  <= '0;
            r_cfg.body_radius    <= 31'd19661;
            r_cfg.half_height    <= 31'd22938;
            r_cfg.cloud_required <= 1'b1;
            r_cfg.check_enable   <= 1'b0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                rcc_pkg::CFG_CENTER_X:  r_cfg.cen_x          <= i_cfg_data;
                rcc_pkg::CFG_CENTER_Y:  r_cfg.cen_y          <= i_cfg_data;
                rcc_pkg::CFG_PATH_H:    r_cfg.path_height    <= i_cfg_data;
                rcc_pkg::CFG_CIRCLE_R:  r_cfg.circle_radius  <= i_cfg_data[30:0];
                rcc_pkg::CFG_BODY_R:    r_cfg.body_radius    <= i_cfg_data[30:0];
                rcc_pkg::CFG_HALF_H:    r_cfg.half_height    <= i_cfg_data[30:0];
                rcc_pkg::CFG_CLOUD_REQ: r_cfg.cloud_required <= i_cfg_data[0];
                rcc_pkg::CFG_CHECK_EN:  r_cfg.check_enable   <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    rcc_front u_front (
        .i_cfg       (r_cfg),
        .i_px        (i_s_tdata[31:0]),
        .i_py        (i_s_tdata[63:32]),
        .i_pz        (i_s_tdata[95:64]),
        .i_finite    (i_s_tuser[0]),
        .i_no_points (i_s_tuser[1]),
        .i_last      (i_s_tlast),
        .o_entry     (front_entry)
    );

    rcc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (front_entry),
        .i_pop   (q_pop),
        .o_entry (q_entry),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    rcc_back #(.COUNT_BITS(COUNT_BITS)) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_entry   (q_entry),
        .i_q_empty (q_empty),
        .o_pop     (q_pop),
        .o_valid   (o_m_tvalid),
        .i_ready   (i_m_tready),
        .o_data    (o_m_tdata)
    );
endmodule

// ===== hdl/rcc_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcc_front: point classifier
// Forms |dx|, |dy| against the circle center and the slab test on z.
// ----------------------------------------------------------------------------
module rcc_front (
    input  rcc_pkg::t_cfg       i_cfg,
    input  logic signed [31:0]  i_px,
    input  logic signed [31:0]  i_py,
    input  logic signed [31:0]  i_pz,
    input  logic                i_finite,
    input  logic                i_no_points,
    input  logic                i_last,
    output rcc_pkg::t_entry     o_entry
);
    logic signed [32:0] dx, dy, dz;
    logic signed [33:0] dz_w, hh_w;
    logic [32:0]        ax_w, ay_w;

    always_comb begin
        dx   = {i_px[31], i_px} - {i_cfg.cen_x[31], i_cfg.cen_x};
        dy   = {i_py[31], i_py} - {i_cfg.cen_y[31], i_cfg.cen_y};
        dz   = {i_pz[31], i_pz} - {i_cfg.path_height[31], i_cfg.path_height};
        ax_w = dx[32] ? 33'(-dx) : 33'(dx);
        ay_w = dy[32] ? 33'(-dy) : 33'(dy);
        dz_w = {dz[32], dz};
        hh_w = {3'b000, i_cfg.half_height};
        o_entry.is_empty = i_no_points;
        o_entry.finite   = i_finite;
        o_entry.in_slab  = (dz_w >= -hh_w) && (dz_w <= hh_w);
        o_entry.last     = i_last;
        o_entry.x        = i_px;
        o_entry.y        = i_py;
        o_entry.ax       = ax_w[31:0];
        o_entry.ay       = ay_w[31:0];
    end
endmodule

// ===== hdl/rcc_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcc_queue: short entry queue
// Decouples the classifier from the arithmetic back end.
// ----------------------------------------------------------------------------
module rcc_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  rcc_pkg::t_entry i_entry,
    input  logic            i_pop,
    output rcc_pkg::t_entry o_entry,
    output logic            o_full,
    output logic            o_empty
);
    localparam int D  = rcc_pkg::QUEUE_DEPTH;
    localparam int IW = (D > 1) ? $clog2(D) : 1;
    localparam int CW = $clog2(D + 1);

    rcc_pkg::t_entry r_mem [D];
    logic [IW-1:0]   r_wp, r_rp;
    logic [CW-1:0]   r_cnt;

    assign o_full  = (r_cnt == CW'(D));
    assign o_empty = (r_cnt == '0);
    assign o_entry = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push)
            r_mem[r_wp] <= i_entry;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push)
                r_wp <= (r_wp == IW'(D - 1)) ? '0 : r_wp + 1'b1;
            if (i_pop)
                r_rp <= (r_rp == IW'(D - 1)) ? '0 : r_rp + 1'b1;
            if (i_push && !i_pop)
                r_cnt <= r_cnt + 1'b1;
            else if (!i_push && i_pop)
                r_cnt <= r_cnt - 1'b1;
        end
    end
endmodule

// ===== hdl/rcc_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcc_back: accumulator and verdict engine
// Squares, bit-serial square root, gap tracking, box and verdict output.
// ----------------------------------------------------------------------------
module rcc_back #(
    parameter int COUNT_BITS = 24
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  rcc_pkg::t_cfg   i_cfg,
    input  rcc_pkg::t_entry i_entry,
    input  logic            i_q_empty,
    output logic            o_pop,
    output logic            o_valid,
    input  logic            i_ready,
    output logic [63:0]     o_data
);
    localparam int OW = (COUNT_BITS > 24) ? COUNT_BITS : 24;

    typedef enum logic [2:0] {
        S_IDLE, S_MUL, S_SUM, S_SQRT, S_GAP, S_OUT
    } t_state;

    t_state                  r_state;
    logic                    r_last, r_kind_empty;
    logic [31:0]             r_ax, r_ay;
    logic [63:0]             r_sx, r_sy;
    logic [65:0]             r_val;
    logic [34:0]             r_rem;
    logic [32:0]             r_root;
    logic [5:0]              r_step;
    logic signed [31:0]      r_min_x, r_max_x, r_min_y, r_max_y;
    logic [COUNT_BITS-1:0]   r_count;
    logic [31:0]             r_gap;
    logic                    r_ovalid;
    logic [63:0]             r_odata;

    logic [36:0] rem_sh, test;
    logic signed [33:0] diff;
    logic [33:0] adiff;
    logic [31:0] gap32;
    logic [OW-1:0] cnt_w;
    logic [23:0] cnt_o;
    logic signed [33:0] ext, cx, cy;
    logic in_box, out_free, load_out;
    logic safe_o;
    logic [2:0] code_o;
    logic [23:0] count_o;
    logic [31:0] gapo;
    logic in_o;

    assign out_free = !r_ovalid || i_ready;
    assign load_out = (r_state == S_OUT) && out_free;
    assign o_pop    = (r_state == S_IDLE) && !i_q_empty;
    assign o_valid  = r_ovalid;
    assign o_data   = r_odata;

    always_comb begin
        rem_sh = {r_rem, r_val[65:64]};
        test   = {2'b00, r_root, 2'b01};
        diff   = $signed({1'b0, r_root}) - $signed({3'b000, i_cfg.circle_radius});
        adiff  = diff[33] ? 34'(-diff) : 34'(diff);
        gap32  = (adiff[33:32] != 2'b00) ? 32'hFFFF_FFFF : adiff[31:0];
        cnt_w  = OW'(r_count);
        cnt_o  = (cnt_w > OW'(24'hFF_FFFF)) ? 24'hFF_FFFF : cnt_w[23:0];
        ext    = $signed({3'b000, i_cfg.circle_radius}) + $signed({3'b000, i_cfg.body_radius});
        cx     = 34'(i_cfg.cen_x);
        cy     = 34'(i_cfg.cen_y);
        in_box = (cx - ext >= 34'(r_min_x)) && (cx + ext <= 34'(r_max_x)) &&
                 (cy - ext >= 34'(r_min_y)) && (cy + ext <= 34'(r_max_y));
        safe_o  = 1'b1;
        code_o  = rcc_pkg::RC_DISABLED;
        count_o = '0;
        gapo    = 32'hFFFF_FFFF;
        in_o    = 1'b0;
        if (!i_cfg.check_enable) begin
            safe_o = 1'b1;
        end else if (r_kind_empty) begin
            if (i_cfg.cloud_required) begin
                safe_o = 1'b0;
                code_o = rcc_pkg::RC_MISSING;
            end
        end else if (r_count == '0) begin
            safe_o = 1'b0;
            code_o = rcc_pkg::RC_EMPTY;
            gapo   = r_gap;
        end else begin
            count_o = cnt_o;
            gapo    = r_gap;
            if (!in_box) begin
                safe_o = 1'b0;
                code_o = rcc_pkg::RC_BOUNDS;
            end else if (r_gap < {1'b0, i_cfg.body_radius}) begin
                safe_o = 1'b0;
                code_o = rcc_pkg::RC_LOW;
                in_o   = 1'b1;
            end else begin
                code_o = rcc_pkg::RC_SAFE;
                in_o   = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_ovalid     <= 1'b0;
            r_min_x      <= 32'sh7FFF_FFFF;
            r_min_y      <= 32'sh7FFF_FFFF;
            r_max_x      <= 32'sh8000_0000;
            r_max_y      <= 32'sh8000_0000;
            r_count      <= '0;
            r_gap        <= 32'hFFFF_FFFF;
            r_last       <= 1'b0;
            r_kind_empty <= 1'b0;
            r_step       <= '0;
        end else begin
            if (load_out)
                r_ovalid <= 1'b1;
            else if (r_ovalid && i_ready)
                r_ovalid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (!i_q_empty) begin
                        r_last       <= i_entry.last;
                        r_kind_empty <= i_entry.is_empty;
                        r_ax         <= i_entry.ax;
                        r_ay         <= i_entry.ay;
                        if (i_entry.is_empty) begin
                            r_state <= S_OUT;
                        end else begin
                            if (i_entry.finite) begin
                                if (i_entry.x < r_min_x) r_min_x <= i_entry.x;
                                if (i_entry.x > r_max_x) r_max_x <= i_entry.x;
                                if (i_entry.y < r_min_y) r_min_y <= i_entry.y;
                                if (i_entry.y > r_max_y) r_max_y <= i_entry.y;
                            end
                            if (i_entry.finite && i_entry.in_slab) begin
                                if (r_count != {COUNT_BITS{1'b1}})
                                    r_count <= r_count + 1'b1;
                                r_state <= S_MUL;
                            end else if (i_entry.last) begin
                                r_state <= S_OUT;
                            end
                        end
                    end
                end
                S_MUL: begin
                    r_sx    <= r_ax * r_ax;
                    r_sy    <= r_ay * r_ay;
                    r_state <= S_SUM;
                end
                S_SUM: begin
                    r_val   <= {1'b0, 65'(r_sx) + 65'(r_sy)};
                    r_rem   <= '0;
                    r_root  <= '0;
                    r_step  <= 6'd32;
                    r_state <= S_SQRT;
                end
                S_SQRT: begin
                    if (rem_sh >= test) begin
                        r_rem  <= 35'(rem_sh - test);
                        r_root <= {r_root[31:0], 1'b1};
                    end else begin
                        r_rem  <= rem_sh[34:0];
                        r_root <= {r_root[31:0], 1'b0};
                    end
                    r_val <= {r_val[63:0], 2'b00};
                    if (r_step == '0)
                        r_state <= S_GAP;
                    else
                        r_step <= r_step - 1'b1;
                end
                S_GAP: begin
                    if (gap32 < r_gap)
                        r_gap <= gap32;
                    r_state <= r_last ? S_OUT : S_IDLE;
                end
                S_OUT: begin
                    if (out_free) begin
                        r_odata  <= {3'b000, in_o, gapo, count_o, code_o, safe_o};
                        r_min_x  <= 32'sh7FFF_FFFF;
                        r_min_y  <= 32'sh7FFF_FFFF;
                        r_max_x  <= 32'sh8000_0000;
                        r_max_y  <= 32'sh8000_0000;
                        r_count  <= '0;
                        r_gap    <= 32'hFFFF_FFFF;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> (r_state == S_IDLE))
        else $error("entry popped while busy");
    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SQRT) |-> (r_step <= 6'd32))
        else $error("root step out of range");
    a_out_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && out_free) |=> (r_ovalid && r_count == '0))
        else $error("verdict did not clear state");
endmodule
